[design/omou_pkg.sv]
// shared constants, types and the arctangent table for the motion orientation update
// no dependencies
package omou_pkg;

	localparam int COORD_BITS      = 12;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int ANG_Q           = 16;
	localparam int CORDIC_STEPS    = 23;
	localparam int SQRT_STEPS      = 14;
	localparam int DIV_STEPS       = 15;

	localparam int CTR_W = 13;
	localparam int D_W   = 14;
	localparam int H_W   = 15;
	localparam int LEN_W = 14;
	localparam int SQ_W  = 26;
	localparam int V_W   = 28;
	localparam int XY_W  = 32;
	localparam int Z_W   = 26;
	localparam int P_W   = 30;
	localparam int DEN_W = 15;

	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_DOWN  = 3'd1;
	localparam logic [2:0] DIR_UP_B  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_LEFT  = 3'd4;

	localparam logic signed [H_W-1:0] T45  = H_W'(45 <<< ANGLE_FRAC_BITS);
	localparam logic signed [H_W-1:0] T90  = H_W'(90 <<< ANGLE_FRAC_BITS);
	localparam logic signed [H_W-1:0] T135 = H_W'(135 <<< ANGLE_FRAC_BITS);
	localparam logic signed [H_W-1:0] T180 = H_W'(180 <<< ANGLE_FRAC_BITS);
	localparam logic signed [Z_W-1:0] Z180 = Z_W'(180 <<< ANG_Q);

	typedef logic [2:0] dir_t;

	typedef struct packed {
		logic [CTR_W-1:0]        cx;
		logic [CTR_W-1:0]        cy;
		logic [CTR_W-1:0]        pcx;
		logic [CTR_W-1:0]        pcy;
		logic signed [D_W-1:0]   dx;
		logic signed [D_W-1:0]   dy;
		logic                    moved;
		logic signed [H_W-1:0]   h0;
		logic [LEN_W-1:0]        m0;
		logic [SQ_W-1:0]         sqx;
		logic [SQ_W-1:0]         sqy;
		logic [V_W-1:0]          v;
		logic [V_W-1:0]          root;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
		logic                    axis;
		logic signed [H_W-1:0]   t_axis;
		logic signed [H_W-1:0]   t;
		logic [LEN_W-1:0]        len;
		logic signed [P_W-1:0]   pa;
		logic signed [P_W-1:0]   pb;
		logic                    neg;
		logic [P_W-1:0]          rem;
		logic [DEN_W-1:0]        den;
		logic [H_W-1:0]          quo;
	} pipe_t;

	function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:  r = Z_W'(2949120);
			5'd1:  r = Z_W'(1740967);
			5'd2:  r = Z_W'(919879);
			5'd3:  r = Z_W'(466945);
			5'd4:  r = Z_W'(234379);
			5'd5:  r = Z_W'(117306);
			5'd6:  r = Z_W'(58666);
			5'd7:  r = Z_W'(29335);
			5'd8:  r = Z_W'(14668);
			5'd9:  r = Z_W'(7334);
			5'd10: r = Z_W'(3667);
			5'd11: r = Z_W'(1833);
			5'd12: r = Z_W'(917);
			5'd13: r = Z_W'(458);
			5'd14: r = Z_W'(229);
			5'd15: r = Z_W'(115);
			5'd16: r = Z_W'(57);
			5'd17: r = Z_W'(29);
			5'd18: r = Z_W'(14);
			5'd19: r = Z_W'(7);
			5'd20: r = Z_W'(4);
			5'd21: r = Z_W'(2);
			5'd22: r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[design/omou_if.sv]
// handshake channels for the object pair word and the result word
// depends on omou_pkg
interface omou_in_if;
	import omou_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  prev_left;
	logic [COORD_BITS-1:0]  prev_top;
	logic [COORD_BITS-1:0]  prev_width;
	logic [COORD_BITS-1:0]  prev_height;
	logic [CTR_W-1:0]       prev_center_x;
	logic [CTR_W-1:0]       prev_center_y;
	logic signed [H_W-1:0]  prev_heading;
	logic [LEN_W-1:0]       prev_step_length;
	logic [COORD_BITS-1:0]  cur_left;
	logic [COORD_BITS-1:0]  cur_top;
	logic [COORD_BITS-1:0]  cur_width;
	logic [COORD_BITS-1:0]  cur_height;
	modport source (output valid, prev_left, prev_top, prev_width, prev_height,
		prev_center_x, prev_center_y, prev_heading, prev_step_length,
		cur_left, cur_top, cur_width, cur_height, input ready);
	modport sink (input valid, prev_left, prev_top, prev_width, prev_height,
		prev_center_x, prev_center_y, prev_heading, prev_step_length,
		cur_left, cur_top, cur_width, cur_height, output ready);
endinterface

interface omou_out_if;
	import omou_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [H_W-1:0]  heading;
	logic [LEN_W-1:0]       step_length;
	logic [CTR_W-1:0]       center_x;
	logic [CTR_W-1:0]       center_y;
	logic                   moved;
	logic                   detect;
	modport source (output valid, heading, step_length, center_x, center_y, moved, detect,
		input ready);
	modport sink (input valid, heading, step_length, center_x, center_y, moved, detect,
		output ready);
endinterface

[design/omou_cell.sv]
// one cordic micro-rotation plus, when sqrt_en is set, one square-root digit, registered
// depends on omou_pkg
module omou_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  omou_pkg::pipe_t d,
	input  logic [4:0]    idx,
	input  logic          sqrt_en,
	input  logic [4:0]    bit_pos,
	output logic          vld_q,
	output omou_pkg::pipe_t q
);
	import omou_pkg::*;

	pipe_t                  nxt;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic [V_W-1:0]         bitv;
	logic [V_W:0]           trial;

	always_comb begin
		nxt   = d;
		xs    = d.x >>> idx;
		ys    = d.y >>> idx;
		bitv  = V_W'(1) << bit_pos;
		trial = {1'b0, d.root} + {1'b0, bitv};
		if (d.y > 0) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + atan_q16(idx);
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - atan_q16(idx);
		end
		if (sqrt_en) begin
			if ({1'b0, d.v} >= trial) begin
				nxt.v    = d.v - trial[V_W-1:0];
				nxt.root = (d.root >> 1) + bitv;
			end else begin
				nxt.root = d.root >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[design/omou_div_cell.sv]
// one restoring division digit of the weighted heading average, registered
// depends on omou_pkg
module omou_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  omou_pkg::pipe_t d,
	input  logic [3:0]    bit_pos,
	output logic          vld_q,
	output omou_pkg::pipe_t q
);
	import omou_pkg::*;

	pipe_t          nxt;
	logic [P_W-1:0] trial;

	always_comb begin
		nxt   = d;
		trial = P_W'(d.den) << bit_pos;
		if (d.rem >= trial) begin
			nxt.rem          = d.rem - trial;
			nxt.quo[bit_pos] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[design/object_motion_orientation_update.sv]
// Heading and step length update for one matched object pair per word. The block takes a
// word in every cycle unless the output stalls, and passes it through three setup stages, a row of
// 23 cells that each do one cordic rotation (the first 14 also one square-root digit),
// three product stages, a row of 15 restoring-division cells and an output register.
// The whole row advances together, held only while the output word is not taken.
// depends on omou_pkg, omou_if, omou_cell, omou_div_cell
module object_motion_orientation_update (
	input  logic             clk,
	input  logic             arst_n,
	omou_in_if.sink          in_ch,
	omou_out_if.source       out_ch,
	input  logic             cfg_we,
	input  omou_pkg::dir_t   cfg_data
);
	import omou_pkg::*;

	logic  en;
	dir_t  dir_q;

	pipe_t s1, s2, s3, s1_n, s2_n, s3_n;
	logic  v_s1, v_s2;
	pipe_t cs [CORDIC_STEPS+1];
	logic  cv [CORDIC_STEPS+1];
	pipe_t p1, p2, p3, p1_n, p2_n, p3_n;
	logic  v_p1, v_p2;
	pipe_t ds [DIV_STEPS+1];
	logic  dv [DIV_STEPS+1];

	logic [CTR_W-1:0]       px, py, cx, cy;
	logic signed [Z_W-1:0]  zr;
	logic signed [H_W-1:0]  h_fin;
	logic signed [H_W-1:0]  heading_q;
	logic [LEN_W-1:0]       step_q;
	logic [CTR_W-1:0]       cx_q, cy_q;
	logic                   moved_q, det_q, out_v_q, det_n;

	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_UP;
		end else if (cfg_we) begin
			dir_q <= cfg_data;
		end
	end

	// centers and displacement
	always_comb begin
		s1_n = '0;
		px = CTR_W'(in_ch.prev_left) + CTR_W'(in_ch.prev_width >> 1);
		py = CTR_W'(in_ch.prev_top) + CTR_W'(in_ch.prev_height >> 1);
		cx = CTR_W'(in_ch.cur_left) + CTR_W'(in_ch.cur_width >> 1);
		cy = CTR_W'(in_ch.cur_top) + CTR_W'(in_ch.cur_height >> 1);
		s1_n.cx    = cx;
		s1_n.cy    = cy;
		s1_n.pcx   = in_ch.prev_center_x;
		s1_n.pcy   = in_ch.prev_center_y;
		s1_n.dx    = D_W'(cx) - D_W'(px);
		s1_n.dy    = D_W'(cy) - D_W'(py);
		s1_n.moved = (cx != px) || (cy != py);
		s1_n.h0    = in_ch.prev_heading;
		s1_n.m0    = in_ch.prev_step_length;
	end

	// squares
	always_comb begin
		s2_n     = s1;
		s2_n.sqx = SQ_W'(s1.dx * s1.dx);
		s2_n.sqy = SQ_W'(s1.dy * s1.dy);
	end

	// radicand and cordic start vector
	always_comb begin
		s3_n      = s2;
		s3_n.v    = V_W'(s2.sqx) + V_W'(s2.sqy);
		s3_n.root = '0;
		s3_n.x    = {{(XY_W-D_W-ANG_Q){s2.dx[D_W-1]}}, s2.dx, {ANG_Q{1'b0}}};
		s3_n.y    = {{(XY_W-D_W-ANG_Q){s2.dy[D_W-1]}}, s2.dy, {ANG_Q{1'b0}}};
		s3_n.z    = '0;
		if (s2.dx < 0) begin
			s3_n.z = (s2.dy >= 0) ? Z180 : -Z180;
			s3_n.x = -s3_n.x;
			s3_n.y = -s3_n.y;
		end
		s3_n.axis = (s2.dx == '0) || (s2.dy == '0);
		if (s2.dx == '0) begin
			s3_n.t_axis = (s2.dy > 0) ? T90 : -T90;
		end else begin
			s3_n.t_axis = (s2.dx > 0) ? '0 : T180;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			cv[0] <= 1'b0;
		end else if (en) begin
			v_s1  <= in_ch.valid;
			v_s2  <= v_s1;
			cv[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1 <= s1_n;
			s2 <= s2_n;
			s3 <= s3_n;
		end
	end

	assign cs[0] = s3;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		omou_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_i   (cv[k]),
			.d       (cs[k]),
			.idx     (5'(k)),
			.sqrt_en ((k < SQRT_STEPS) ? 1'b1 : 1'b0),
			.bit_pos ((k < SQRT_STEPS) ? 5'(2 * (SQRT_STEPS - 1 - k)) : 5'd0),
			.vld_q   (cv[k+1]),
			.q       (cs[k+1])
		);
	end

	// rounded angle and length
	always_comb begin
		p1_n     = cs[CORDIC_STEPS];
		zr       = cs[CORDIC_STEPS].z + Z_W'(1 <<< (ANG_Q - ANGLE_FRAC_BITS - 1));
		p1_n.t   = cs[CORDIC_STEPS].axis ? cs[CORDIC_STEPS].t_axis
			: H_W'(zr >>> (ANG_Q - ANGLE_FRAC_BITS));
		p1_n.len = cs[CORDIC_STEPS].root[LEN_W-1:0];
	end

	// weight products
	always_comb begin
		p2_n    = p1;
		p2_n.pa = P_W'(signed'({1'b0, p1.m0})) * P_W'(p1.h0);
		p2_n.pb = P_W'(signed'({1'b0, p1.len})) * P_W'(p1.t);
	end

	// numerator magnitude and divisor
	always_comb begin
		p3_n      = p2;
		p3_n.neg  = (p2.pa + p2.pb) < 0;
		p3_n.rem  = p3_n.neg ? P_W'(-(p2.pa + p2.pb)) : P_W'(p2.pa + p2.pb);
		p3_n.den  = DEN_W'(p2.m0) + DEN_W'(p2.len);
		p3_n.quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1  <= 1'b0;
			v_p2  <= 1'b0;
			dv[0] <= 1'b0;
		end else if (en) begin
			v_p1  <= cv[CORDIC_STEPS];
			v_p2  <= v_p1;
			dv[0] <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1 <= p1_n;
			p2 <= p2_n;
			p3 <= p3_n;
		end
	end

	assign ds[0] = p3;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		omou_div_cell u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_i   (dv[j]),
			.d       (ds[j]),
			.bit_pos (4'(DIV_STEPS - 1 - j)),
			.vld_q   (dv[j+1]),
			.q       (ds[j+1])
		);
	end

	// sign, sector test and output word
	always_comb begin
		h_fin = ds[DIV_STEPS].neg ? -signed'(ds[DIV_STEPS].quo) : signed'(ds[DIV_STEPS].quo);
		case (dir_q)
			DIR_UP, DIR_UP_B: det_n = (h_fin < -T45) && (h_fin > -T135);
			DIR_DOWN:         det_n = (h_fin > T45) && (h_fin < T135);
			DIR_RIGHT:        det_n = (h_fin < T45) && (h_fin > -T45);
			DIR_LEFT:         det_n = (h_fin < -T135) || (h_fin > T135);
			default:          det_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			moved_q <= ds[DIV_STEPS].moved;
			if (ds[DIV_STEPS].moved) begin
				heading_q <= h_fin;
				step_q    <= LEN_W'((DEN_W'(ds[DIV_STEPS].m0) + DEN_W'(ds[DIV_STEPS].len)) >> 1);
				cx_q      <= ds[DIV_STEPS].cx;
				cy_q      <= ds[DIV_STEPS].cy;
				det_q     <= det_n;
			end else begin
				heading_q <= ds[DIV_STEPS].h0;
				step_q    <= '0;
				cx_q      <= ds[DIV_STEPS].pcx;
				cy_q      <= ds[DIV_STEPS].pcy;
				det_q     <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.heading     = heading_q;
	assign out_ch.step_length = step_q;
	assign out_ch.center_x    = cx_q;
	assign out_ch.center_y    = cy_q;
	assign out_ch.moved       = moved_q;
	assign out_ch.detect      = det_q;

	a_detect_needs_motion: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.moved |-> !out_ch.detect && out_ch.step_length == '0)
		else $error("detect or length set on a still object");

	a_no_sector: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && dir_q != DIR_UP && dir_q != DIR_DOWN && dir_q != DIR_UP_B
		&& dir_q != DIR_RIGHT && dir_q != DIR_LEFT |-> !out_ch.detect)
		else $error("detect set with no sector configured");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready does not follow output stall");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |=> out_ch.valid)
		else $error("pipeline stalled without a pending output word");

endmodule
